// ----- sv/b64d_pkg.sv -----
// shared types, constants and the symbol lookup for the base64 stream decoder
package b64d_pkg;

   localparam int CountWidthDefault = 24;
   localparam int CharWidth         = 8;
   localparam int LimitWidth        = 24;
   localparam int SextetWidth       = 6;
   localparam int StatusWidth       = 2;

   localparam logic [LimitWidth-1:0] LimitReset = {LimitWidth{1'b1}};

   localparam logic [CharWidth-1:0] NoSymbol = 8'h80;
   localparam logic [CharWidth-1:0] PadChar  = 8'h3D;

   localparam logic [StatusWidth-1:0] StatusOk       = 2'd0;
   localparam logic [StatusWidth-1:0] StatusBadCount = 2'd1;
   localparam logic [StatusWidth-1:0] StatusBadPad   = 2'd2;
   localparam logic [StatusWidth-1:0] StatusOverLim  = 2'd3;

   // results produced by one accepted character
   typedef struct packed {
      logic [2:0][CharWidth-1:0] data;
      logic [1:0]                nbytes;
      logic                      has_end;
      logic [StatusWidth-1:0]    status;
   } b64d_group_type;

   // sextet of a character, NoSymbol when the character is skipped
   function automatic logic [CharWidth-1:0] sextet_of(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] r;
      r = NoSymbol;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
         r = 8'd62;
      end else if (c == 8'h2F) begin
         r = 8'd63;
      end else if (c == PadChar) begin
         r = 8'd0;
      end
      return r;
   endfunction

endpackage

// ----- sv/b64d_req_if.sv -----
// character channel of the base64 stream decoder
interface b64d_req_if;
   logic                           valid;
   logic                           ready;
   logic [b64d_pkg::CharWidth-1:0] in_char;
   logic                           last_char;

   modport source (output valid, output in_char, output last_char, input ready);
   modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

// ----- sv/b64d_rsp_if.sv -----
// result channel of the base64 stream decoder
interface b64d_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [b64d_pkg::CharWidth-1:0]   out_byte;
   logic                             is_end;
   logic                             run_last;
   logic [b64d_pkg::StatusWidth-1:0] status_code;

   modport source (output valid, output out_byte, output is_end, output run_last,
                   output status_code, input ready);
   modport sink   (input valid, input out_byte, input is_end, input run_last,
                   input status_code, output ready);
endinterface

// ----- sv/b64d_core.sv -----
// quad assembly, padding tracking and end status of the base64 decoder
module b64d_core #(
   parameter int COUNT_WIDTH = b64d_pkg::CountWidthDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic [b64d_pkg::CharWidth-1:0]  in_char,
   input  logic                            last_char,
   input  logic [b64d_pkg::LimitWidth-1:0] out_limit,
   output b64d_pkg::b64d_group_type        group
);
   import b64d_pkg::*;

   localparam int CmpWidth = ((COUNT_WIDTH > LimitWidth) ? COUNT_WIDTH : LimitWidth) + 1;
   localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

   logic [SextetWidth-1:0] hold_ff [3];
   logic [SextetWidth-1:0] hold_in [3];
   logic [1:0]             slot_ff, slot_in;
   logic [2:0]             pad_ff, pad_in;
   logic                   stopped_ff, stopped_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic                   pad_err_ff, pad_err_in;

   logic [CharWidth-1:0]   sx;
   logic                   is_sym;
   logic [SextetWidth-1:0] s6;
   logic [2:0]             pad_up;
   logic [COUNT_WIDTH-3:0] quads;
   logic [CmpWidth-1:0]    dec_len;
   logic [CmpWidth-1:0]    lim_ext;

   always_comb begin
      sx      = sextet_of(in_char);
      is_sym  = (sx != NoSymbol);
      s6      = sx[SextetWidth-1:0];

      hold_in    = hold_ff;
      slot_in    = slot_ff;
      pad_in     = pad_ff;
      stopped_in = stopped_ff;
      pad_err_in = pad_err_ff;
      total_in   = total_ff;
      pad_up     = pad_ff;

      group.data    = '0;
      group.nbytes  = 2'd0;
      group.has_end = 1'b0;
      group.status  = StatusOk;

      if (is_sym) begin
         if (total_ff != CountMax) begin
            total_in = total_ff + COUNT_WIDTH'(1);
         end
         if (!stopped_ff) begin
            if (in_char == PadChar && pad_ff != 3'd7) begin
               pad_up = pad_ff + 3'd1;
            end
            if (slot_ff != 2'd3) begin
               hold_in[slot_ff] = s6;
               slot_in          = slot_ff + 2'd1;
               pad_in           = pad_up;
            end else begin
               group.data[0] = {hold_ff[0], hold_ff[1][5:4]};
               group.data[1] = {hold_ff[1][3:0], hold_ff[2][5:2]};
               group.data[2] = {hold_ff[2][1:0], s6};
               if (pad_up <= 3'd2) begin
                  group.nbytes = 2'(3'd3 - pad_up);
               end else begin
                  pad_err_in = 1'b1;
               end
               if (pad_up != 3'd0) begin
                  stopped_in = 1'b1;
               end
               slot_in = 2'd0;
               pad_in  = 3'd0;
               hold_in = '{default: '0};
            end
         end
      end

      quads   = total_in[COUNT_WIDTH-1:2];
      dec_len = CmpWidth'({quads, 1'b0}) + CmpWidth'(quads);
      lim_ext = CmpWidth'(out_limit);

      if (last_char) begin
         group.has_end = 1'b1;
         if (total_in == '0 || total_in[1:0] != 2'd0) begin
            group.status = StatusBadCount;
         end else if (dec_len > lim_ext) begin
            group.status = StatusOverLim;
         end else if (pad_err_in) begin
            group.status = StatusBadPad;
         end
         hold_in    = '{default: '0};
         slot_in    = 2'd0;
         pad_in     = 3'd0;
         stopped_in = 1'b0;
         total_in   = '0;
         pad_err_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff    <= '{default: '0};
         slot_ff    <= 2'd0;
         pad_ff     <= 3'd0;
         stopped_ff <= 1'b0;
         total_ff   <= '0;
         pad_err_ff <= 1'b0;
      end else if (fire) begin
         hold_ff    <= hold_in;
         slot_ff    <= slot_in;
         pad_ff     <= pad_in;
         stopped_ff <= stopped_in;
         total_ff   <= total_in;
         pad_err_ff <= pad_err_in;
      end
   end

endmodule

// ----- sv/base64_stream_decoder.sv -----
// top level of the base64 stream decoder: csr, core and result buffer
//
// usage
//  - req_if carries one encoded character per beat (in_char, last_char);
//    characters outside the alphabet are dropped, '=' counts as a pad
//  - rsp_if carries one result per beat: a data byte, or on the last
//    character an end beat (is_end=1) with status_code 0 ok, 1 bad symbol
//    count, 2 bad padding, 3 over limit; run_last marks the final result
//    caused by one character
//  - csr_wr_en/csr_wr_data write out_limit, the largest decoded length
//    allowed; write it only while the block is idle
//  - one character is decoded in the cycle it is accepted; its results
//    show up on rsp_if from the next cycle, one beat per cycle while rsp_if.ready is high
//  - a new character is taken in every cycle in which the result buffer
//    is empty or is handing out its final beat, so the rsp port sets the pace
//  - a stalled receiver holds the buffer and, through it, req_if.ready
//  - reset (synchronous) clears the stream state, empties the buffer and
//    sets out_limit to all ones
module base64_stream_decoder #(
   parameter int COUNT_WIDTH = b64d_pkg::CountWidthDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   b64d_req_if.sink                        req_if,
   b64d_rsp_if.source                      rsp_if,
   input  logic                            csr_wr_en,
   input  logic [b64d_pkg::LimitWidth-1:0] csr_wr_data
);
   import b64d_pkg::*;

   logic [LimitWidth-1:0] limit_ff;

   b64d_group_type        group_in;
   b64d_group_type        group_ff;
   logic [2:0]            grp_total_ff;   // results held for the last character
   logic [2:0]            grp_pos_ff;     // next result to hand out

   logic                  req_fire;
   logic                  rsp_fire;
   logic                  rsp_final;
   logic [2:0]            group_total;

   // config register; the user must write it only while idle, the block itself does not enforce that
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitReset;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   b64d_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .in_char   (req_if.in_char),
      .last_char (req_if.last_char),
      .out_limit (limit_ff),
      .group     (group_in)
   );

   // result buffer: data beats first, then the end beat
   assign rsp_if.valid = (grp_pos_ff < grp_total_ff);
   assign rsp_final    = (grp_pos_ff == grp_total_ff - 3'd1);
   assign rsp_fire     = rsp_if.valid && rsp_if.ready;

   // take a new character once the buffer drains this cycle or is empty
   assign req_if.ready = !rsp_if.valid || (rsp_fire && rsp_final);
   assign req_fire     = req_if.valid && req_if.ready;

   assign group_total  = {1'b0, group_in.nbytes} + {2'b00, group_in.has_end};

   always_comb begin
      rsp_if.run_last    = rsp_final;
      if (grp_pos_ff < {1'b0, group_ff.nbytes}) begin
         rsp_if.out_byte    = group_ff.data[grp_pos_ff[1:0]];
         rsp_if.is_end      = 1'b0;
         rsp_if.status_code = StatusOk;
      end else begin
         rsp_if.out_byte    = '0;
         rsp_if.is_end      = 1'b1;
         rsp_if.status_code = group_ff.status;
      end
   end

   // payload register needs no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         group_ff <= group_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_total_ff <= 3'd0;
         grp_pos_ff   <= 3'd0;
      end else if (req_fire) begin
         grp_total_ff <= group_total;
         grp_pos_ff   <= 3'd0;
      end else if (rsp_fire) begin
         grp_pos_ff   <= grp_pos_ff + 3'd1;
      end
   end

endmodule

// ----- tb/sv/b64d_tb_pkg.sv -----
// beat types and the decoding tracker used by the base64 stream decoder testbench
package b64d_tb_pkg;
   import b64d_pkg::*;

   typedef struct {
      logic [CharWidth-1:0]   data;
      logic                   is_end;
      logic                   run_last;
      logic [StatusWidth-1:0] status;
   } decoded_beat_type;

   // sextet value of an alphabet character or the pad, 0 when the character is skipped
   function automatic bit alphabet_value(input logic [CharWidth-1:0] c,
                                         output logic [SextetWidth-1:0] v);
      logic [CharWidth-1:0] t;
      t = 8'h00;
      alphabet_value = 1'b1;
      if (c >= 8'h41 && c <= 8'h5A) begin
         t = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         t = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
         t = 8'd62;
      end else if (c == 8'h2F) begin
         t = 8'd63;
      end else if (c != PadChar) begin
         alphabet_value = 1'b0;
      end
      v = t[SextetWidth-1:0];
   endfunction

   class b64_decode_tracker;
      logic [LimitWidth-1:0]        byte_limit;
      logic [SextetWidth-1:0]       held [3];
      logic [1:0]                   slot;
      logic [2:0]                   pads;
      bit                           halted;
      logic [CountWidthDefault-1:0] sym_count;
      bit                           pad_bad;
      decoded_beat_type             due [$];

      function new();
         byte_limit = LimitReset;
         clear_text();
      endfunction

      function void clear_text();
         foreach (held[i]) held[i] = '0;
         slot      = '0;
         pads      = '0;
         halted    = 1'b0;
         sym_count = '0;
         pad_bad   = 1'b0;
      endfunction

      function void set_limit(input logic [LimitWidth-1:0] v);
         byte_limit = v;
      endfunction

      function int beats_pending();
         return due.size();
      endfunction

      function decoded_beat_type make_beat(input logic [CharWidth-1:0] d, input logic e,
                                           input logic [StatusWidth-1:0] st);
         decoded_beat_type b;
         b.data     = d;
         b.is_end   = e;
         b.run_last = 1'b0;
         b.status   = st;
         return b;
      endfunction

      // works out the beats one accepted character causes and queues them
      function void take_char(input logic [CharWidth-1:0] c, input bit last);
         decoded_beat_type       grp [$];
         logic [SextetWidth-1:0] s;
         logic [CharWidth-1:0]   b0, b1, b2;
         logic [StatusWidth-1:0] st;
         longint                 decoded_len;
         if (alphabet_value(c, s)) begin
            if (sym_count != '1) sym_count++;
            if (!halted) begin
               if (c == PadChar && pads < 3'd7) pads++;
               if (slot < 2'd3) begin
                  held[slot] = s;
                  slot++;
               end else begin
                  b0 = {held[0], held[1][5:4]};
                  b1 = {held[1][3:0], held[2][5:2]};
                  b2 = {held[2][1:0], s};
                  if (pads <= 3'd2) begin
                     grp.push_back(make_beat(b0, 1'b0, StatusOk));
                     if (pads <= 3'd1) grp.push_back(make_beat(b1, 1'b0, StatusOk));
                     if (pads == 3'd0) grp.push_back(make_beat(b2, 1'b0, StatusOk));
                  end else begin
                     pad_bad = 1'b1;
                  end
                  if (pads != 3'd0) halted = 1'b1;
                  slot = '0;
                  pads = '0;
                  foreach (held[i]) held[i] = '0;
               end
            end
         end
         if (last) begin
            decoded_len = (longint'(sym_count) >> 2) * 3;
            if (sym_count == '0 || sym_count[1:0] != 2'b00) st = StatusBadCount;
            else if (decoded_len > longint'(byte_limit)) st = StatusOverLim;
            else if (pad_bad) st = StatusBadPad;
            else st = StatusOk;
            grp.push_back(make_beat('0, 1'b1, st));
            clear_text();
         end
         if (grp.size() > 0) grp[grp.size()-1].run_last = 1'b1;
         foreach (grp[i]) due.push_back(grp[i]);
      endfunction

      // compares one result beat with the oldest one due, empty string on a match
      function string check_beat(input logic [CharWidth-1:0] d, input logic e,
                                 input logic r, input logic [StatusWidth-1:0] st);
         decoded_beat_type want;
         if (due.size() == 0)
            return $sformatf("unexpected beat byte=%h end=%b last=%b status=%0d", d, e, r, st);
         want = due.pop_front();
         if (d !== want.data || e !== want.is_end || r !== want.run_last ||
             st !== want.status)
            return $sformatf("beat byte=%h end=%b last=%b status=%0d, want %h %b %b %0d",
                             d, e, r, st, want.data, want.is_end, want.run_last,
                             want.status);
         return "";
      endfunction
   endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// top of the base64 stream decoder testbench: clock, reset, drivers, checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;
   import b64d_tb_pkg::*;

   // generous cycle budget for the whole run
   localparam int CycleLimit = 200000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [LimitWidth-1:0] csr_wr_data;

   b64d_req_if req_if ();
   b64d_rsp_if rsp_if ();

   base64_stream_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   b64_decode_tracker    tracker;
   int                   mismatches  = 0;
   int                   chars_sent  = 0;
   int                   cycle_count = 0;
   bit                   steady      = 1'b0;   // no idling on either side while set
   logic [CharWidth-1:0] text [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("check error at %0t: %s", $time, msg);
   endtask

   // result side: every accepted beat goes against the oldest one due
   always @(posedge clock) begin
      string msg;
      if (!reset && tracker != null && rsp_if.valid && rsp_if.ready) begin
         msg = tracker.check_beat(rsp_if.out_byte, rsp_if.is_end, rsp_if.run_last,
                                  rsp_if.status_code);
         if (msg != "") report_mismatch(msg);
      end
   end

   // receiver stalls at random, about 30 percent of the time, unless steady is set
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = steady || ($urandom_range(0, 99) >= 30);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", CycleLimit);
         $display("Mismatches found");
         $finish;
      end
   end

   // one character beat, at times with a random gap in front of it unless steady is set
   task automatic send_char(input logic [CharWidth-1:0] c, input bit last);
      @(negedge clock);
      if (!steady && $urandom_range(0, 99) < 30) begin
         req_if.valid     = 1'b0;
         req_if.in_char   = CharWidth'($urandom_range(0, 255));
         req_if.last_char = 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_if.valid     = 1'b1;
      req_if.in_char   = c;
      req_if.last_char = last;
      do @(posedge clock); while (!req_if.ready);
      tracker.take_char(c, last);
      chars_sent++;
   endtask

   // whole text from a string, end flag on its final character
   task automatic send_string(input string s);
      for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
   endtask

   function automatic logic [CharWidth-1:0] symbol_char(input int v);
      if (v < 26) return CharWidth'(8'h41 + v);        // upper case
      if (v < 52) return CharWidth'(8'h61 + v - 26);   // lower case
      if (v < 62) return CharWidth'(8'h30 + v - 52);   // digits
      if (v == 62) return 8'h2B;                       // plus
      return 8'h2F;                                    // slash
   endfunction

   // any byte that is neither an alphabet character nor the pad
   function automatic logic [CharWidth-1:0] noise_char();
      logic [CharWidth-1:0]   c;
      logic [SextetWidth-1:0] v;
      do c = CharWidth'($urandom_range(0, 255)); while (alphabet_value(c, v));
      return c;
   endfunction

   // mostly well-formed texts with random content, the rest broken or plain noise
   task automatic send_random_text();
      int nquads;
      int npads;
      int roll;
      text.delete();
      nquads = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
      npads  = $urandom_range(0, 2);
      for (int k = 0; k < nquads * 4; k++) begin
         if ($urandom_range(0, 9) == 0) text.push_back(noise_char());
         if (k >= nquads * 4 - npads) text.push_back(PadChar);
         else text.push_back(symbol_char($urandom_range(0, 63)));
      end
      roll = $urandom_range(0, 99);
      if (roll >= 92) begin
         // plain random bytes, full range
         text.delete();
         repeat ($urandom_range(0, 8)) text.push_back(CharWidth'($urandom_range(0, 255)));
      end else if (roll >= 84) begin
         // extra symbols or pads behind the text, decoded or ignored after a pad
         repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 3) == 0) text.push_back(PadChar);
            else text.push_back(symbol_char($urandom_range(0, 63)));
         end
      end else if (roll >= 77) begin
         // pads in odd places, up to whole pad quads
         repeat ($urandom_range(1, 4)) text[$urandom_range(0, text.size() - 1)] = PadChar;
      end else if (roll >= 70) begin
         // a dropped character breaks the quad count
         text.delete($urandom_range(0, text.size() - 1));
      end
      // end flag now and then on a skipped character
      if (text.size() == 0 || $urandom_range(0, 4) == 0) text.push_back(noise_char());
      for (int k = 0; k < text.size(); k++) send_char(text[k], k == text.size() - 1);
   endtask

   // block idle: input dropped, nothing due, then a wait for a character still in flight
   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (tracker.beats_pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LimitWidth-1:0] v);
      drain();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      tracker.set_limit(v);
   endtask

   initial begin
      int                    goal;
      logic [LimitWidth-1:0] lim;
      tracker          = new();
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_if.valid     = 1'b0;
      req_if.in_char   = '0;
      req_if.last_char = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, limit at its reset value
      send_char(8'h00, 1'b0);       // lowest byte, skipped
      send_string("+/9z");          // top sextets, full quad
      send_char(8'hFF, 1'b0);       // highest byte, skipped
      send_string("////");          // all ones out
      send_string("AA==QUJD");      // two pads, then symbols counted but not decoded
      send_string("A===");          // three pads in a quad: bad padding
      send_string("Az");            // symbol count not a multiple of four
      send_char(8'h2A, 1'b1);       // end flag with no symbols at all

      // random phases over several limits, one of them without any idling
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 0) lim = '0;
         else if (phase == 1) lim = LimitWidth'($urandom_range(0, 12));
         else if (phase == 2) lim = LimitReset;
         else if (phase == 3) lim = LimitWidth'($urandom_range(3, 18));
         else lim = LimitWidth'($urandom_range(0, 24'hFFFFFF));
         write_limit(lim);
         steady = (phase == 2);
         goal   = chars_sent + 16;
         while (chars_sent < goal) send_random_text();
      end
      @(negedge clock);
      req_if.valid = 1'b0;
      steady       = 1'b0;

      // wait for every beat due, then a while more for strays
      while (tracker.beats_pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
